>>> hw/rtl/esc_pkg.sv
package esc_pkg;

	// Internal widths cover the widest supported input of 40 bits.
	localparam int SECS_W = 40;
	localparam int LOW_W = 7;
	localparam int T_W = SECS_W - LOW_W;
	localparam int CHUNK_W = 11;
	localparam int MUL_STEPS = T_W / CHUNK_W;
	localparam int CNT_W = $clog2(MUL_STEPS);
	localparam int RECIP_W = 34;
	localparam int PART_W = CHUNK_W + RECIP_W;
	localparam int DAYS_W = 24;
	localparam int DAY_SHIFT = 43;
	localparam int PROD_W = DAY_SHIFT + DAYS_W;
	localparam int YEAR_W = 16;

	localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS - 1);

	// Seconds shifted down by 7 leave a division by 675 for whole days. The reciprocal
	// is 2^43 / 675 rounded up, which is exact for every 33-bit dividend.
	localparam logic [RECIP_W-1:0] RECIP_DAY = RECIP_W'(64'd13031248922);
	localparam logic [9:0] DAY_UNITS = 10'd675;
	// 2^29 / 3600, 2^18 / 60 and 2^28 / 7, each rounded up.
	localparam logic [17:0] RECIP_HOUR = 18'd149131;
	localparam logic [12:0] RECIP_MIN = 13'd4370;
	localparam logic [25:0] RECIP_WEEK = 26'd38347923;
	localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
	localparam logic [5:0] SECS_PER_MIN = 6'd60;

	localparam logic [DAYS_W-1:0] DAYS_PER_400Y = DAYS_W'(146097);
	// The leap cycle starts at the year 2000 plus a multiple of 400; 1970 is at position 370.
	localparam logic [YEAR_W-1:0] BASE_YEAR_OFS = YEAR_W'(70);
	localparam logic [YEAR_W-1:0] YEARS_PER_CYCLE = YEAR_W'(400);
	localparam logic [8:0] BASE_CYCLE_POS = 9'd370;
	localparam logic [8:0] LAST_CYCLE_POS = 9'd399;
	localparam logic [3:0] EPOCH_WEEKDAY = 4'd4;
	localparam logic [3:0] DAYS_PER_WEEK = 4'd7;
	localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL_STEP,
		OP_DAYS,
		OP_SPLIT,
		OP_HOUR,
		OP_REST,
		OP_MINUTE,
		OP_SECOND,
		OP_YEAR_STEP,
		OP_MONTH_STEP,
		OP_PUBLISH
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic year_done;
		logic month_done;
	} status_t;

	function automatic logic [8:0] month_len(input logic [3:0] m, input logic leap);
		logic [8:0] n;
		case (m)
			4'd1:    n = leap ? 9'd29 : 9'd28;
			4'd3:    n = 9'd30;
			4'd5:    n = 9'd30;
			4'd8:    n = 9'd30;
			4'd10:   n = 9'd30;
			default: n = 9'd31;
		endcase
		return n;
	endfunction

endpackage

>>> hw/rtl/esc_ctrl.sv
module esc_ctrl
	import esc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_DAYS,
		ST_SPLIT,
		ST_HOUR,
		ST_REST,
		ST_MINUTE,
		ST_SECOND,
		ST_YEAR,
		ST_MONTH,
		ST_PUBLISH
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             pub_fire;

	assign pub_fire  = (state_q == ST_PUBLISH) && (!out_valid_q || !out_stall);
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		case (state_q)
			ST_IDLE:    cmd.op = in_valid ? OP_LOAD : OP_NONE;
			ST_MUL:     cmd.op = OP_MUL_STEP;
			ST_DAYS:    cmd.op = OP_DAYS;
			ST_SPLIT:   cmd.op = OP_SPLIT;
			ST_HOUR:    cmd.op = OP_HOUR;
			ST_REST:    cmd.op = OP_REST;
			ST_MINUTE:  cmd.op = OP_MINUTE;
			ST_SECOND:  cmd.op = OP_SECOND;
			ST_YEAR:    cmd.op = OP_YEAR_STEP;
			ST_MONTH:   cmd.op = OP_MONTH_STEP;
			ST_PUBLISH: cmd.op = pub_fire ? OP_PUBLISH : OP_NONE;
			default:    cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pub_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_MUL;
						cnt_q   <= '0;
					end
				end
				ST_MUL: begin
					if (cnt_q == MUL_LAST) begin
						state_q <= ST_DAYS;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				ST_DAYS: begin
					state_q <= ST_SPLIT;
				end
				ST_SPLIT: begin
					state_q <= ST_HOUR;
				end
				ST_HOUR: begin
					state_q <= ST_REST;
				end
				ST_REST: begin
					state_q <= ST_MINUTE;
				end
				ST_MINUTE: begin
					state_q <= ST_SECOND;
				end
				ST_SECOND: begin
					state_q <= ST_YEAR;
				end
				ST_YEAR: begin
					if (status.year_done) begin
						state_q <= ST_MONTH;
					end
				end
				ST_MONTH: begin
					if (status.month_done) begin
						state_q <= ST_PUBLISH;
					end
				end
				ST_PUBLISH: begin
					if (pub_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/esc_datapath.sv
module esc_datapath
	import esc_pkg::*;
#(
	parameter int SECONDS_BITS = 34
) (
	input  logic                    clk,
	input  cmd_t                    cmd,
	input  logic [SECONDS_BITS-1:0] epoch_seconds,
	output status_t                 status,
	output logic [5:0]              second_of_minute,
	output logic [5:0]              minute_of_hour,
	output logic [4:0]              hour_of_day,
	output logic [2:0]              weekday,
	output logic [9:0]              years_since_1900,
	output logic [8:0]              day_of_year,
	output logic [3:0]              month_index,
	output logic [4:0]              day_of_month
);

	localparam int WNUM_W = DAYS_W + 1;
	localparam int WPROD_W = WNUM_W + 26;

	logic [SECS_W-1:0]  secs_ext;
	logic [T_W-1:0]     t_q;
	logic [T_W-1:0]     mul_q;
	logic [LOW_W-1:0]   low_q;
	logic [PROD_W-1:0]  acc_q;
	logic [DAYS_W-1:0]  days_q;
	logic [16:0]        sod_q;
	logic [WNUM_W-1:0]  wnum_q;
	logic [22:0]        wquo_q;
	logic [11:0]        rest_q;
	logic [DAYS_W-1:0]  dr_q;
	logic [YEAR_W-1:0]  yr_q;
	logic [8:0]         ypos_q;
	logic [3:0]         mon_q;
	logic [5:0]         sec_q;
	logic [5:0]         min_q;
	logic [4:0]         hour_q;
	logic [2:0]         wday_q;
	logic [8:0]         doy_q;

	logic [PART_W-1:0]  part;
	logic [T_W-1:0]     day_prod;
	logic [9:0]         day_rem;
	logic [34:0]        hprod;
	logic [WPROD_W-1:0] wprod;
	logic [24:0]        mprod;
	logic               leap;
	logic [8:0]         ylen;
	logic [8:0]         mlen;

	assign secs_ext = SECS_W'(epoch_seconds);

	// The reciprocal product is built from the top chunk of the dividend down.
	assign part = PART_W'(mul_q[T_W-1 -: CHUNK_W]) * RECIP_DAY;

	assign day_prod = T_W'(days_q) * DAY_UNITS;
	assign day_rem  = 10'(t_q - day_prod);
	assign hprod    = 35'(sod_q) * RECIP_HOUR;
	assign wprod    = WPROD_W'(wnum_q) * RECIP_WEEK;
	assign mprod    = 25'(rest_q) * RECIP_MIN;

	// Position within the 400-year cycle decides leap years.
	assign leap = (ypos_q[1:0] == 2'b00) && (ypos_q != 9'd100) && (ypos_q != 9'd200)
		&& (ypos_q != 9'd300);
	assign ylen = leap ? 9'd366 : 9'd365;
	assign mlen = month_len(mon_q, leap);

	assign status.year_done  = (dr_q < DAYS_W'(ylen));
	assign status.month_done = (mon_q == MONTHS_PER_YEAR) || (dr_q < DAYS_W'(mlen));

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				t_q   <= secs_ext[SECS_W-1:LOW_W];
				mul_q <= secs_ext[SECS_W-1:LOW_W];
				low_q <= secs_ext[LOW_W-1:0];
				acc_q <= '0;
			end
			OP_MUL_STEP: begin
				acc_q <= (acc_q << CHUNK_W) + PROD_W'(part);
				mul_q <= mul_q << CHUNK_W;
			end
			OP_DAYS: begin
				days_q <= acc_q[PROD_W-1:DAY_SHIFT];
			end
			OP_SPLIT: begin
				sod_q  <= {day_rem, low_q};
				wnum_q <= WNUM_W'(days_q) + WNUM_W'(EPOCH_WEEKDAY);
			end
			OP_HOUR: begin
				hour_q <= hprod[33:29];
				wquo_q <= wprod[50:28];
			end
			OP_REST: begin
				rest_q <= 12'(sod_q - 17'(hour_q) * SECS_PER_HOUR);
				wday_q <= 3'(wnum_q - WNUM_W'(wquo_q) * DAYS_PER_WEEK);
			end
			OP_MINUTE: begin
				min_q <= mprod[23:18];
			end
			OP_SECOND: begin
				sec_q  <= 6'(rest_q - 12'(min_q) * SECS_PER_MIN);
				yr_q   <= BASE_YEAR_OFS;
				ypos_q <= BASE_CYCLE_POS;
				dr_q   <= days_q;
			end
			OP_YEAR_STEP: begin
				// Whole 400-year cycles go first and leave the leap pattern unchanged.
				if (dr_q >= DAYS_PER_400Y) begin
					dr_q <= dr_q - DAYS_PER_400Y;
					yr_q <= yr_q + YEARS_PER_CYCLE;
				end else if (status.year_done) begin
					doy_q <= dr_q[8:0];
					mon_q <= '0;
				end else begin
					dr_q   <= dr_q - DAYS_W'(ylen);
					yr_q   <= yr_q + 1'b1;
					ypos_q <= (ypos_q == LAST_CYCLE_POS) ? 9'd0 : ypos_q + 1'b1;
				end
			end
			OP_MONTH_STEP: begin
				if (!status.month_done) begin
					dr_q  <= dr_q - DAYS_W'(mlen);
					mon_q <= mon_q + 1'b1;
				end
			end
			OP_PUBLISH: begin
				second_of_minute <= sec_q;
				minute_of_hour   <= min_q;
				hour_of_day      <= hour_q;
				weekday          <= wday_q;
				years_since_1900 <= yr_q[9:0];
				day_of_year      <= doy_q;
				month_index      <= mon_q;
				day_of_month     <= dr_q[4:0] + 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> hw/rtl/epoch_seconds_to_calendar.sv
// Converts seconds since 1970-01-01 UTC into a broken-down UTC calendar time.
// It loads the input, builds the reciprocal product, takes whole days, splits off hours,
// weekday, minutes and seconds, walks 400-year cycles, years and months, and registers
// the result. The next item is taken the cycle after the result is registered, and no
// item is taken while one is in flight; a stalled earlier result holds the new one back.
// Reset clears the controller and the output valid; data registers are not reset.
module epoch_seconds_to_calendar
	import esc_pkg::*;
#(
	parameter int SECONDS_BITS = 34
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [SECONDS_BITS-1:0] epoch_seconds,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [5:0]              second_of_minute,
	output logic [5:0]              minute_of_hour,
	output logic [4:0]              hour_of_day,
	output logic [2:0]              weekday,
	output logic [9:0]              years_since_1900,
	output logic [8:0]              day_of_year,
	output logic [3:0]              month_index,
	output logic [4:0]              day_of_month
);

	cmd_t    cmd;
	status_t status;

	esc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	esc_datapath #(
		.SECONDS_BITS(SECONDS_BITS)
	) u_datapath (
		.clk              (clk),
		.cmd              (cmd),
		.epoch_seconds    (epoch_seconds),
		.status           (status),
		.second_of_minute (second_of_minute),
		.minute_of_hour   (minute_of_hour),
		.hour_of_day      (hour_of_day),
		.weekday          (weekday),
		.years_since_1900 (years_since_1900),
		.day_of_year      (day_of_year),
		.month_index      (month_index),
		.day_of_month     (day_of_month)
	);

endmodule
